>>> src/bcnvs_pkg.sv
// ----------------------------------------------------------------------------
// bcnvs_pkg
// Shared types and constants for the best-cost near-vertex search block.
// ----------------------------------------------------------------------------
package bcnvs_pkg;

  // Default table size and the largest number of entries that can be written.
  localparam int ENTRIES_DEF  = 256;
  localparam int WRITABLE_MAX = 256;

  // Field widths fixed by the item format.
  localparam int COORD_W = 16;
  localparam int COST_W  = 32;
  localparam int IDX_W   = 8;
  localparam int NUM_DIM = 4;

  // Squares and sums of squares.
  localparam int SQ_W  = 2 * COORD_W;
  localparam int ACC_W = SQ_W + 2;

  // Reset value of the ball radius register.
  localparam logic [COORD_W-1:0] RADIUS_RESET = 16'd1024;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RADSQ = 3'b010,
    ST_SCAN  = 3'b100
  } bcnvs_state_t;

endpackage

>>> src/best_cost_near_vertex_search.sv
// ----------------------------------------------------------------------------
// best_cost_near_vertex_search
// Table of planner vertices with a query that returns the cheapest vertex
// within a ball around a sample state, or the nearest vertex otherwise.
// ----------------------------------------------------------------------------
// A write beat (in_operation low) loads or removes one table entry; busy
// never rises for it. A query beat (in_operation high) keeps busy high while
// the radius is squared and N entries are scanned, where N is ENTRIES capped
// at 256. The one 16x16 squaring multiplier handles one coordinate of one
// entry per cycle and also squares the radius; busy stays high until the
// pipeline drains. The result appears for exactly one cycle with out_valid
// high, in the same cycle that busy falls; the receiver cannot stall it, so it
// must capture the beat then. The table resets to empty; stored coordinates
// and costs are undefined until written, but an unwritten entry is never
// active and so never read by a query. The radius register may be written
// only while busy is low.
// ----------------------------------------------------------------------------
module best_cost_near_vertex_search
  import bcnvs_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      start,
  output logic                      busy,
  input  logic                      in_operation,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic                      in_entry_valid,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_vel_x,
  input  logic signed [COORD_W-1:0] in_vel_y,
  input  logic [COST_W-1:0]         in_path_cost,

  output logic                      out_valid,
  output logic                      out_found,
  output logic [IDX_W-1:0]          out_chosen_index,
  output logic                      out_from_ball,

  input  logic                      cfg_wr_en,
  input  logic [COORD_W-1:0]        cfg_wr_data
);

  // Only the first 256 entries can ever be written, so only those are stored
  // and scanned; the rest would stay inactive forever.
  localparam int SCAN  = (ENTRIES < WRITABLE_MAX) ? ENTRIES : WRITABLE_MAX;
  localparam int AW    = $clog2(SCAN);
  localparam int CNT_W = AW + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCAN * NUM_DIM - 1);

  // Entry storage. Coordinates are packed x, y, vx, vy with x in the low bits.
  logic [NUM_DIM*COORD_W-1:0] coord_mem [SCAN];
  logic [COST_W-1:0]          cost_mem  [SCAN];
  logic [SCAN-1:0]            active_r;

  bcnvs_state_t state_r;
  logic [COORD_W-1:0]        ball_radius_r;
  logic [SQ_W-1:0]           r2_r;
  logic signed [COORD_W-1:0] samp_r [NUM_DIM];

  // Scan issue counter: entry index in the upper bits, coordinate in the low two.
  logic [CNT_W-1:0] cnt_r;
  logic             issuing_r;

  // Stage 1: registered table read.
  logic                       s1_vld_r;
  logic [1:0]                 s1_k_r;
  logic [AW-1:0]              s1_idx_r;
  logic [NUM_DIM*COORD_W-1:0] coord_q;
  logic [COST_W-1:0]          cost_q;
  logic                       act_q;

  // Stage 2: registered square of one coordinate difference.
  logic                s2_vld_r;
  logic [1:0]          s2_k_r;
  logic [AW-1:0]       s2_idx_r;
  logic [COST_W-1:0]   s2_cost_r;
  logic                s2_act_r;
  logic [SQ_W-1:0]     sq_r;

  // Stage 3: accumulated squared distance of a whole entry.
  logic                s3_vld_r;
  logic [AW-1:0]       s3_idx_r;
  logic [COST_W-1:0]   s3_cost_r;
  logic                s3_act_r;
  logic [ACC_W-1:0]    acc_r;

  // Running best candidates.
  logic                any_r;
  logic [ACC_W-1:0]    near_d_r;
  logic [AW-1:0]       near_idx_r;
  logic                ball_any_r;
  logic [COST_W-1:0]   ball_cost_r;
  logic [AW-1:0]       ball_idx_r;

  logic                out_valid_r;
  logic                out_found_r;
  logic [IDX_W-1:0]    out_chosen_index_r;
  logic                out_from_ball_r;

  logic                accept;
  logic                wr_hit;
  logic [AW-1:0]       rd_addr;
  logic                scan_done;
  logic signed [COORD_W-1:0] comp_sel;
  logic signed [COORD_W-1:0] samp_sel;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag_ext;
  logic [COORD_W-1:0]        mag;
  logic [COORD_W-1:0]        mul_op;
  logic [SQ_W-1:0]           product;
  logic                      in_ball;
  logic                      take_ball;
  logic                      take_near;

  assign accept  = start && !busy;
  assign wr_hit  = accept && (in_operation == OP_WRITE)
                   && (32'(in_entry_index) < 32'(ENTRIES));
  assign rd_addr = cnt_r[CNT_W-1:2];

  // The query is finished once issue has stopped and all stages are empty.
  assign scan_done = (state_r == ST_SCAN) && !issuing_r
                     && !s1_vld_r && !s2_vld_r && !s3_vld_r;

  // Table writes happen only while idle, so they never race a scan read.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      coord_mem[in_entry_index[AW-1:0]] <= {in_vel_y, in_vel_x, in_pos_y, in_pos_x};
      cost_mem[in_entry_index[AW-1:0]]  <= in_path_cost;
    end
    coord_q <= coord_mem[rd_addr];
    cost_q  <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      act_q    <= 1'b0;
    end else begin
      if (wr_hit) begin
        active_r[in_entry_index[AW-1:0]] <= in_entry_valid;
      end
      act_q <= active_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      ball_radius_r <= cfg_wr_data;
    end
  end

  // Sequencer and issue counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      issuing_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_operation == OP_QUERY)) begin
            state_r <= ST_RADSQ;
          end
        end
        ST_RADSQ: begin
          state_r   <= ST_SCAN;
          cnt_r     <= '0;
          issuing_r <= 1'b1;
        end
        ST_SCAN: begin
          if (issuing_r) begin
            if (cnt_r == CNT_LAST) begin
              issuing_r <= 1'b0;
            end else begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
          if (scan_done) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_operation == OP_QUERY)) begin
      samp_r[0] <= in_pos_x;
      samp_r[1] <= in_pos_y;
      samp_r[2] <= in_vel_x;
      samp_r[3] <= in_vel_y;
    end
  end

  // Coordinate select and absolute difference for the shared multiplier.
  always_comb begin
    unique case (s1_k_r)
      2'd0: begin
        comp_sel = $signed(coord_q[0*COORD_W +: COORD_W]);
        samp_sel = samp_r[0];
      end
      2'd1: begin
        comp_sel = $signed(coord_q[1*COORD_W +: COORD_W]);
        samp_sel = samp_r[1];
      end
      2'd2: begin
        comp_sel = $signed(coord_q[2*COORD_W +: COORD_W]);
        samp_sel = samp_r[2];
      end
      default: begin
        comp_sel = $signed(coord_q[3*COORD_W +: COORD_W]);
        samp_sel = samp_r[3];
      end
    endcase
    diff    = $signed({comp_sel[COORD_W-1], comp_sel})
              - $signed({samp_sel[COORD_W-1], samp_sel});
    mag_ext = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
    // A difference of two 16-bit values has magnitude below 2^16.
    mag     = mag_ext[COORD_W-1:0];
    // In the radius cycle the same multiplier squares the ball radius.
    mul_op  = (state_r == ST_RADSQ) ? ball_radius_r : mag;
    product = SQ_W'(mul_op) * SQ_W'(mul_op);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RADSQ) begin
      r2_r <= product;
    end
    sq_r      <= product;
    s1_k_r    <= cnt_r[1:0];
    s1_idx_r  <= rd_addr;
    s2_k_r    <= s1_k_r;
    s2_idx_r  <= s1_idx_r;
    s2_cost_r <= cost_q;
    s2_act_r  <= act_q;
    if (s2_vld_r) begin
      acc_r <= ((s2_k_r == 2'd0) ? '0 : acc_r) + ACC_W'(sq_r);
    end
    s3_idx_r  <= s2_idx_r;
    s3_cost_r <= s2_cost_r;
    s3_act_r  <= s2_act_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_SCAN) && issuing_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && (s2_k_r == 2'd3);
    end
  end

  // Compare stage. Entries arrive in ascending order, so strict compares keep
  // the lowest index on ties. The ball boundary counts as inside.
  assign in_ball   = (acc_r <= ACC_W'(r2_r));
  assign take_ball = s3_vld_r && s3_act_r && in_ball
                     && (!ball_any_r || (s3_cost_r < ball_cost_r));
  assign take_near = s3_vld_r && s3_act_r && (!any_r || (acc_r < near_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r      <= 1'b0;
      ball_any_r <= 1'b0;
    end else if (state_r == ST_RADSQ) begin
      any_r      <= 1'b0;
      ball_any_r <= 1'b0;
    end else begin
      if (take_ball) begin
        ball_any_r <= 1'b1;
      end
      if (take_near) begin
        any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_ball) begin
      ball_cost_r <= s3_cost_r;
      ball_idx_r  <= s3_idx_r;
    end
    if (take_near) begin
      near_d_r   <= acc_r;
      near_idx_r <= s3_idx_r;
    end
  end

  // Result beat: one cycle, registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r        <= 1'b0;
      out_found_r        <= 1'b0;
      out_chosen_index_r <= '0;
      out_from_ball_r    <= 1'b0;
    end else begin
      out_valid_r <= scan_done;
      if (scan_done) begin
        out_found_r     <= any_r;
        out_from_ball_r <= ball_any_r;
        if (ball_any_r) begin
          out_chosen_index_r <= IDX_W'(ball_idx_r);
        end else if (any_r) begin
          out_chosen_index_r <= IDX_W'(near_idx_r);
        end else begin
          out_chosen_index_r <= '0;
        end
      end
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_chosen_index = out_chosen_index_r;
  assign out_from_ball    = out_from_ball_r;

  // A result beat only follows the end of a scan.
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SCAN))
    else $error("result beat without a finished scan");

  // A ball hit implies at least one active entry.
  a_ball_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_from_ball |-> out_found)
    else $error("ball result without any active entry");

  // A query beat makes the block busy; a write beat does not.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == OP_WRITE) |=> !busy)
    else $error("write beat made the block busy");

  // Pipeline is empty whenever no scan runs.
  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !s1_vld_r && !s2_vld_r && !s3_vld_r)
    else $error("scan pipeline active while idle");

endmodule
